### hw/rtl/sem_pkg.sv
// sobel edge magnitude package: sizes, field widths, window type, register indexes
// no dependencies
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WREG_W     = 12;
  localparam int HREG_W     = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // gradient, square and root widths
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 21;
  localparam int RT_W   = 22;

  typedef logic [23:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;
  typedef logic [2:0][7:0] mag_t;

endpackage

### hw/rtl/sem_if.sv
// channel interfaces for the sobel edge magnitude block
// depends on sem_pkg
interface sem_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  modport source (output valid, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface sem_out_if;
  import sem_pkg::*;
  logic             valid;
  logic             ready;
  logic [7:0]       edge_red;
  logic [7:0]       edge_green;
  logic [7:0]       edge_blue;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_column;
  logic             last_of_run;
  modport source (output valid, edge_red, edge_green, edge_blue, out_row, out_column,
                  last_of_run, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, out_row, out_column,
                  last_of_run, output ready);
endinterface

### hw/rtl/sobel_edge_magnitude_rgb.sv
// sobel 3x3 gradient magnitude on an rgb raster stream, top level
// depends on sem_pkg, sem_if (sem_in_if, sem_out_if) and sem_mag
//
// usage:
//   in_ch takes one rgb pixel per transfer in raster order; out_ch gives the
//   clamped rounded sobel magnitude per channel with the row and column of the
//   center pixel, last_of_run marking the final result of an input pixel
//   cfg_we/cfg_index/cfg_data write image_width (index 0) and image_height
//   (index 1); write only while the block is idle
//   an input pixel causes 0 to 4 results; the end of a row or of the frame
//   flushes the centers whose missing neighbours lie outside the frame
//   sequence: a pixel that causes no result goes through the line store read,
//   then the read-modify-write; each result then passes the magnitude unit
//   (gradient, square, 11 root steps, rounding) plus its output transfer
//   the next pixel is taken once all results of the previous one are out
//   reset: counters and window clear, sizes return to 2048 x 4096; the line
//   stores are not cleared and need no clearing pass
//   a stalled receiver holds the result in the output register and the
//   block waits with in_ch.ready low
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  sem_in_if.sink                in_ch,
  sem_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_PICK = 5'b00100,
    S_CALC = 5'b01000,
    S_SEND = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [WREG_W-1:0] img_w_r;
  logic [HREG_W-1:0] img_h_r;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;

  // raster position
  logic [ROW_W-1:0] row_cnt_r;
  logic [COL_W-1:0] col_cnt_r;
  logic [ROW_W-1:0] r_cur;
  logic [COL_W-1:0] c_cur;
  logic last_col, last_row;

  // the item at work
  logic [ROW_W-1:0] itm_row_r;
  logic [COL_W-1:0] itm_col_r;
  logic [3:0]       pend_r;
  logic [1:0]       sel_r;
  logic [1:0]       sel_nxt;
  pix_t             pix_r;
  win_t             win_r;

  // line stores
  pix_t older_mem [MAX_WIDTH];
  pix_t newer_mem [MAX_WIDTH];
  pix_t older_q, newer_q;

  logic accept;
  logic mag_start, mag_done;
  mag_t mag;
  win_t mag_win;

  logic             ovalid_r;
  mag_t             omag_r;
  logic [ROW_W-1:0] orow_r;
  logic [COL_W-1:0] ocol_r;
  logic             olast_r;

  // window as seen by a center moved by (dr, dc); outside counts as zero
  function automatic win_t shift_win(input win_t w, input logic dr, input logic dc);
    win_t res;
    int a, b;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a = i + int'(dr);
        b = j + int'(dc);
        if (a <= 2 && b <= 2) res[i][j] = w[a][b];
        else res[i][j] = '0;
      end
    end
    return res;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= WREG_W'(MAX_WIDTH);
      img_h_r <= HREG_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_data[WREG_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_data[HREG_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range sizes saturate to 1 or the maximum
  always_comb begin
    if (img_w_r == '0) w_eff = WREG_W'(1);
    else if (img_w_r > WREG_W'(MAX_WIDTH)) w_eff = WREG_W'(MAX_WIDTH);
    else w_eff = img_w_r;
    if (img_h_r == '0) h_eff = HREG_W'(1);
    else if (img_h_r > HREG_W'(MAX_HEIGHT)) h_eff = HREG_W'(MAX_HEIGHT);
    else h_eff = img_h_r;
  end

  // counters beyond a shrunk size are taken as the last column or row
  always_comb begin
    logic [WREG_W-1:0] wm1;
    logic [HREG_W-1:0] hm1;
    wm1 = w_eff - WREG_W'(1);
    hm1 = h_eff - HREG_W'(1);
    c_cur = (WREG_W'(col_cnt_r) >= w_eff) ? wm1[COL_W-1:0] : col_cnt_r;
    r_cur = (HREG_W'(row_cnt_r) >= h_eff) ? hm1[ROW_W-1:0] : row_cnt_r;
    last_col = (WREG_W'(c_cur) == wm1);
    last_row = (HREG_W'(r_cur) == hm1);
  end

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // accept: latch pixel, read both line stores, advance the raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      pend_r    <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt_r <= '0;
        row_cnt_r <= last_row ? '0 : r_cur + ROW_W'(1);
      end else begin
        col_cnt_r <= c_cur + COL_W'(1);
        row_cnt_r <= r_cur;
      end
      // centers ready: up-left, up (end of row), left (last row), own (last pixel)
      pend_r[0] <= (r_cur != '0) && (c_cur != '0);
      pend_r[1] <= (r_cur != '0) && last_col;
      pend_r[2] <= last_row && (c_cur != '0);
      pend_r[3] <= last_row && last_col;
    end else if (state_r == S_CALC && mag_done) begin
      pend_r[sel_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      itm_row_r <= r_cur;
      itm_col_r <= c_cur;
      pix_r     <= {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue};
      older_q   <= older_mem[c_cur];
      newer_q   <= newer_mem[c_cur];
    end
  end

  // write back: the column moves up one row in the line stores
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      older_mem[itm_col_r] <= newer_q;
      newer_mem[itm_col_r] <= pix_r;
    end
  end

  // window slides left; first column starts with zero neighbours
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (state_r == S_READ) begin
      for (int i = 0; i < 3; i++) begin
        if (itm_col_r == '0) begin
          win_r[i][0] <= '0;
          win_r[i][1] <= '0;
        end else begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
      end
      win_r[0][2] <= (itm_row_r >= ROW_W'(2)) ? older_q : '0;
      win_r[1][2] <= (itm_row_r != '0) ? newer_q : '0;
      win_r[2][2] <= pix_r;
    end
  end

  // first pending result in emit order
  always_comb begin
    if (pend_r[0]) sel_nxt = 2'd0;
    else if (pend_r[1]) sel_nxt = 2'd1;
    else if (pend_r[2]) sel_nxt = 2'd2;
    else sel_nxt = 2'd3;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PICK) sel_r <= sel_nxt;
  end

  assign mag_start = (state_r == S_PICK);
  assign mag_win   = shift_win(win_r, sel_nxt[1], sel_nxt[0]);

  sem_mag u_mag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mag_start),
    .win   (mag_win),
    .done  (mag_done),
    .mag   (mag)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_READ;
      S_READ:  state_nxt = (pend_r != '0) ? S_PICK : S_IDLE;
      S_PICK:  state_nxt = S_CALC;
      S_CALC:  if (mag_done) state_nxt = S_SEND;
      S_SEND:  if (out_ch.ready) state_nxt = (pend_r != '0) ? S_PICK : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CALC && mag_done) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  // output register: position from the item and the moved center
  always_ff @(posedge clk) begin
    if (state_r == S_CALC && mag_done) begin
      omag_r  <= mag;
      orow_r  <= sel_r[1] ? itm_row_r : itm_row_r - ROW_W'(1);
      ocol_r  <= sel_r[0] ? itm_col_r : itm_col_r - COL_W'(1);
      olast_r <= ((pend_r & ~(4'b0001 << sel_r)) == 4'b0000);
    end
  end

  assign out_ch.valid       = ovalid_r;
  assign out_ch.edge_red    = omag_r[0];
  assign out_ch.edge_green  = omag_r[1];
  assign out_ch.edge_blue   = omag_r[2];
  assign out_ch.out_row     = orow_r;
  assign out_ch.out_column  = ocol_r;
  assign out_ch.last_of_run = olast_r;

  a_pick_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PICK |-> pend_r != '0) else $error("pick with nothing pending");
  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    mag_done |-> state_r == S_CALC) else $error("magnitude done out of place");
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_READ) else $error("accept not followed by store read");
  a_valid_send: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> state_r == S_SEND) else $error("result shown outside send");

endmodule

### hw/rtl/sem_mag.sv
// sobel gradient and rounded magnitude for the three channels of one window
// gradient, square, then an iterative bit-pair square root; depends on sem_pkg
module sem_mag
  import sem_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  win_t win,
  output logic done,
  output mag_t mag
);

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_SQ   = 4'b0010,
    M_ROOT = 4'b0100,
    M_FIN  = 4'b1000
  } mstate_t;

  mstate_t state_r, state_nxt;

  logic signed [GRAD_W-1:0] gx_r [3];
  logic signed [GRAD_W-1:0] gy_r [3];
  logic signed [GRAD_W-1:0] gx_nxt [3];
  logic signed [GRAD_W-1:0] gy_nxt [3];
  logic [RT_W-1:0] rem_r [3];
  logic [RT_W-1:0] root_r [3];
  logic [RT_W-1:0] bit_r;
  logic done_r;
  mag_t mag_r;

  function automatic logic signed [GRAD_W-1:0] px(input pix_t p, input int ch);
    return $signed({3'b000, p[8*(2-ch) +: 8]});
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      gx_nxt[ch] = px(win[0][2], ch) + (px(win[1][2], ch) <<< 1) + px(win[2][2], ch)
                 - px(win[0][0], ch) - (px(win[1][0], ch) <<< 1) - px(win[2][0], ch);
      gy_nxt[ch] = px(win[2][0], ch) + (px(win[2][1], ch) <<< 1) + px(win[2][2], ch)
                 - px(win[0][0], ch) - (px(win[0][1], ch) <<< 1) - px(win[0][2], ch);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      M_IDLE:  if (start) state_nxt = M_SQ;
      M_SQ:    state_nxt = M_ROOT;
      M_ROOT:  if (bit_r == RT_W'(1)) state_nxt = M_FIN;
      M_FIN:   state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == M_FIN);
    end
  end

  always_ff @(posedge clk) begin
    logic signed [2*GRAD_W-1:0] sx, sy;
    logic [RT_W-1:0] trial;
    case (state_r)
      M_IDLE: begin
        for (int ch = 0; ch < 3; ch++) begin
          gx_r[ch] <= gx_nxt[ch];
          gy_r[ch] <= gy_nxt[ch];
        end
      end
      M_SQ: begin
        for (int ch = 0; ch < 3; ch++) begin
          sx = gx_r[ch] * gx_r[ch];
          sy = gy_r[ch] * gy_r[ch];
          rem_r[ch]  <= RT_W'({1'b0, sx[SQ_W-1:0]}) + RT_W'({1'b0, sy[SQ_W-1:0]});
          root_r[ch] <= '0;
        end
        bit_r <= RT_W'(1) << (SQ_W - 1);
      end
      M_ROOT: begin
        for (int ch = 0; ch < 3; ch++) begin
          trial = root_r[ch] + bit_r;
          if (rem_r[ch] >= trial) begin
            rem_r[ch]  <= rem_r[ch] - trial;
            root_r[ch] <= (root_r[ch] >> 1) + bit_r;
          end else begin
            root_r[ch] <= root_r[ch] >> 1;
          end
        end
        bit_r <= bit_r >> 2;
      end
      M_FIN: begin
        for (int ch = 0; ch < 3; ch++) begin
          // round to nearest, then clamp
          if (root_r[ch] > RT_W'(255) || (root_r[ch] == RT_W'(255) && rem_r[ch] > root_r[ch]))
            mag_r[ch] <= 8'd255;
          else if (rem_r[ch] > root_r[ch])
            mag_r[ch] <= root_r[ch][7:0] + 8'd1;
          else
            mag_r[ch] <= root_r[ch][7:0];
        end
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign mag  = mag_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == M_IDLE) else $error("start while busy");
  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == M_FIN) |-> done_r) else $error("missing done");
  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == M_ROOT |-> $countones(bit_r) == 1) else $error("bad root step bit");

endmodule
